/* hdl/ghlp_pkg.sv */
`timescale 1ns / 1ps

package ghlp_pkg;

    // Width of the header byte counter.
    localparam int LEN_BITS = 16;

    // Width of the header length limit register.
    localparam int CFG_W = 16;

    // Width in which the byte count and the limit are compared.
    localparam int LIMIT_W = ((LEN_BITS > CFG_W) ? LEN_BITS : CFG_W) + 1;

    // Largest count that the counter itself can represent.
    localparam logic [LIMIT_W-1:0] LEN_MASK = LIMIT_W'({LEN_BITS{1'b1}});

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(256);

    localparam int SKIP_W = 16;

    localparam logic [7:0] MAGIC_ID1 = 8'h1f;
    localparam logic [7:0] MAGIC_ID2 = 8'h8b;

    localparam logic [7:0] FLG_HCRC    = 8'h02;
    localparam logic [7:0] FLG_EXTRA   = 8'h04;
    localparam logic [7:0] FLG_NAME    = 8'h08;
    localparam logic [7:0] FLG_COMMENT = 8'h10;

    // Bytes after FLG that complete the fixed header (MTIME, XFL, OS).
    localparam logic [SKIP_W-1:0] FIXED_SKIP = SKIP_W'(6);
    localparam logic [SKIP_W-1:0] HCRC_SKIP  = SKIP_W'(2);

    // Length of the fixed part of a member header.
    localparam int FIXED_HDR_LEN = 10;

    typedef enum logic [3:0] {
        PH_MAGIC1   = 4'd0,
        PH_MAGIC2   = 4'd1,
        PH_METHOD   = 4'd2,
        PH_FLAGS    = 4'd3,
        PH_FIXED    = 4'd4,
        PH_XLEN_LO  = 4'd5,
        PH_XLEN_HI  = 4'd6,
        PH_XDATA    = 4'd7,
        PH_NAME     = 4'd8,
        PH_COMMENT  = 4'd9,
        PH_HCRC     = 4'd10,
        PH_DRAIN    = 4'd11,
        PH_COMPLETE = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        PART_EXTRA   = 2'd0,
        PART_NAME    = 2'd1,
        PART_COMMENT = 2'd2,
        PART_HCRC    = 2'd3
    } t_part;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_GZIP = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_req;

    typedef struct packed {
        t_status    status;
        logic [15:0] header_length;
        logic [7:0] flag_byte;
        logic [7:0] method_byte;
    } t_out_req;

    // First optional header part present at or after the given part.
    function automatic t_phase next_part(input logic [7:0] flags, input t_part from);
        t_phase ph;
        ph = PH_COMPLETE;
        if (from == PART_EXTRA && (flags & FLG_EXTRA) != 8'h00) begin
            ph = PH_XLEN_LO;
        end else if (from <= PART_NAME && (flags & FLG_NAME) != 8'h00) begin
            ph = PH_NAME;
        end else if (from <= PART_COMMENT && (flags & FLG_COMMENT) != 8'h00) begin
            ph = PH_COMMENT;
        end else if ((flags & FLG_HCRC) != 8'h00) begin
            ph = PH_HCRC;
        end
        return ph;
    endfunction

endpackage

/* hdl/gzip_header_length_parser_unit.sv */
`timescale 1ns / 1ps
// Channel    Direction  Handshake                    Payload
// ---------  ---------  ---------------------------  ---------------------------------
// in         sink       i_in_valid / o_in_ready      i_in_req  (t_in_req)
// out        source     o_out_valid / i_out_ready    o_out_req (t_out_req)
// cfg        sink       i_cfg_wr_en, no wait         i_cfg_wr_data (header length limit)
//
// One byte is accepted every cycle while o_in_ready is high; the rate is set by the
// single phase register and byte counter, which are updated once per accepted byte.
// A result request reaches o_out_valid through the output register or the skid stage.
// Reset is synchronous and active low; it restores the limit to 256 and rearms the parser.
// o_in_ready falls only when both the output register and the skid stage hold results.

module gzip_header_length_parser_unit
    import ghlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_req         o_out_req
);

    // Parser state. The flag and method bytes are reported in every result, so they
    // are cleared on reset and on every rearm, like the rest of the state.
    t_phase              r_phase;
    t_phase              n_phase;
    logic [LEN_BITS-1:0] r_offset;
    logic [7:0]          r_flags;
    logic [7:0]          n_flags;
    logic [7:0]          r_method;
    logic [7:0]          n_method;
    logic [SKIP_W-1:0]   r_skip;
    logic [SKIP_W-1:0]   n_skip;
    logic [7:0]          r_xlen_lo;
    logic [7:0]          n_xlen_lo;
    logic [CFG_W-1:0]    r_max_len;

    logic                w_in_acc;
    logic                w_active;
    logic                w_bad_magic;
    logic [7:0]          w_byte;
    logic [SKIP_W-1:0]   w_skip_dec;
    logic [SKIP_W-1:0]   w_xlen;
    logic [LEN_BITS:0]   w_count;
    logic [LIMIT_W-1:0]  w_cfg_limit;
    logic [LIMIT_W-1:0]  w_limit;
    logic                w_over;
    logic                w_done;
    logic                w_has_result;
    t_out_req            w_result;
    logic                w_can_push;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = w_can_push;
    assign w_byte     = i_in_req.data_byte;
    assign w_active   = (r_phase < PH_DRAIN);
    assign w_skip_dec = r_skip - SKIP_W'(1);
    assign w_xlen     = {w_byte, r_xlen_lo};

    // The count includes the current byte, so it needs one bit beyond the counter.
    assign w_count     = {1'b0, r_offset} + (LEN_BITS + 1)'(1);
    assign w_cfg_limit = LIMIT_W'(r_max_len);
    assign w_limit     = (w_cfg_limit < LEN_MASK) ? w_cfg_limit : LEN_MASK;
    assign w_over      = LIMIT_W'(w_count) > w_limit;

    // Next phase. The optional parts follow in the standard order: extra field, name,
    // comment, then the header CRC.
    always_comb begin
        n_phase     = r_phase;
        w_bad_magic = 1'b0;
        unique case (r_phase)
            PH_MAGIC1: begin
                if (w_byte != MAGIC_ID1) begin
                    w_bad_magic = 1'b1;
                end else begin
                    n_phase = PH_MAGIC2;
                end
            end
            PH_MAGIC2: begin
                if (w_byte != MAGIC_ID2) begin
                    w_bad_magic = 1'b1;
                end else begin
                    n_phase = PH_METHOD;
                end
            end
            PH_METHOD: begin
                n_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                n_phase = PH_FIXED;
            end
            PH_FIXED: begin
                if (w_skip_dec == '0) begin
                    n_phase = next_part(r_flags, PART_EXTRA);
                end
            end
            PH_XLEN_LO: begin
                n_phase = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                n_phase = (w_xlen == '0) ? next_part(r_flags, PART_NAME) : PH_XDATA;
            end
            PH_XDATA: begin
                if (w_skip_dec == '0) begin
                    n_phase = next_part(r_flags, PART_NAME);
                end
            end
            PH_NAME: begin
                if (w_byte == 8'h00) begin
                    n_phase = next_part(r_flags, PART_COMMENT);
                end
            end
            PH_COMMENT: begin
                if (w_byte == 8'h00) begin
                    n_phase = next_part(r_flags, PART_HCRC);
                end
            end
            PH_HCRC: begin
                if (w_skip_dec == '0) begin
                    n_phase = PH_COMPLETE;
                end
            end
            default: begin
                // Drain, complete and unused codes take no part in parsing.
            end
        endcase
    end

    // Captured bytes and the skip counter.
    always_comb begin
        n_method  = (r_phase == PH_METHOD) ? w_byte : r_method;
        n_flags   = (r_phase == PH_FLAGS) ? w_byte : r_flags;
        n_xlen_lo = (r_phase == PH_XLEN_LO) ? w_byte : r_xlen_lo;
        priority if (n_phase == PH_HCRC && r_phase != PH_HCRC) begin
            n_skip = HCRC_SKIP;
        end else if (r_phase == PH_FLAGS) begin
            n_skip = FIXED_SKIP;
        end else if (r_phase == PH_XLEN_HI) begin
            n_skip = w_xlen;
        end else if (r_phase == PH_FIXED || r_phase == PH_XDATA || r_phase == PH_HCRC) begin
            n_skip = w_skip_dec;
        end else begin
            n_skip = r_skip;
        end
    end

    // Result. A bad magic byte beats the length check; the length check beats a
    // finished header; an end of stream with nothing else to say means truncation.
    always_comb begin
        w_done       = !w_bad_magic && (n_phase == PH_COMPLETE);
        w_has_result = w_active &&
                       (w_bad_magic || w_over || w_done || i_in_req.end_of_stream);
        priority if (w_bad_magic) begin
            w_result.status = ST_NOT_GZIP;
        end else if (w_over) begin
            w_result.status = ST_TOO_LONG;
        end else if (w_done) begin
            w_result.status = ST_OK;
        end else begin
            w_result.status = ST_TRUNC;
        end
        w_result.header_length = (w_done && !w_over) ? 16'(w_count) : 16'h0000;
        w_result.flag_byte     = n_flags;
        w_result.method_byte   = n_method;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC1;
            r_offset  <= '0;
            r_flags   <= '0;
            r_method  <= '0;
            r_skip    <= '0;
            r_xlen_lo <= '0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (w_in_acc) begin
                if (i_in_req.end_of_stream) begin
                    // Last byte of the file: rearm for the next member.
                    r_phase   <= PH_MAGIC1;
                    r_offset  <= '0;
                    r_flags   <= '0;
                    r_method  <= '0;
                    r_skip    <= '0;
                    r_xlen_lo <= '0;
                end else begin
                    r_phase   <= (w_has_result || !w_active) ? PH_DRAIN : n_phase;
                    r_flags   <= n_flags;
                    r_method  <= n_method;
                    r_skip    <= n_skip;
                    r_xlen_lo <= n_xlen_lo;
                    if (w_active) begin
                        r_offset <= LEN_BITS'(w_count);
                    end
                end
            end
        end
    end

    // Output register with a skid stage, so that bytes keep flowing while one
    // result waits.
    ghlp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_in_acc && w_has_result),
        .i_push_req  (w_result),
        .o_can_push  (w_can_push),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

`ifndef SYNTHESIS
    // A header reported as good is never shorter than the fixed header.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.status == ST_OK) |->
            (o_out_req.header_length >= 16'(FIXED_HDR_LEN)))
        else $error("good header shorter than the fixed header");

    // The last byte of a file always rearms the parser.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_req.end_of_stream) |=>
            (r_phase == PH_MAGIC1 && r_offset == '0))
        else $error("parser not rearmed after end of stream");

    // Once a result has been given, the rest of the file is drained.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_has_result && !i_in_req.end_of_stream) |=> (r_phase == PH_DRAIN))
        else $error("parser still active after its result");

    // A magic mismatch can only be found while the magic bytes are expected.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_has_result && w_result.status == ST_NOT_GZIP) |->
            (r_phase == PH_MAGIC1 || r_phase == PH_MAGIC2))
        else $error("not-gzip status outside the magic bytes");
`endif

endmodule

/* hdl/ghlp_out_buf.sv */
`timescale 1ns / 1ps

module ghlp_out_buf
    import ghlp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_out_req i_push_req,
    output logic     o_can_push,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    logic     r_main_valid;
    logic     r_skid_valid;
    t_out_req r_main_req;
    t_out_req r_skid_req;
    logic     w_pop;

    assign w_pop       = r_main_valid && i_out_ready;
    assign o_can_push  = !r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_out_req   = r_main_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_main_req <= r_skid_req;
            end
        end else if (i_push) begin
            if (!r_main_valid || w_pop) begin
                r_main_req <= i_push_req;
            end else begin
                r_skid_req <= i_push_req;
            end
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ghlp_pkg::*;

    // A run is declared hung when this many cycles pass without a single request
    // moving on either channel.
    localparam int unsigned QUIET_LIMIT = 2000;

    // Cycles allowed after the last result before the limit register is touched,
    // so that a byte which produces no result has left the pipeline.
    localparam int SETTLE_CYCLES = 8;

    // Cycles of grace at the very end, to catch any stray result.
    localparam int TAIL_CYCLES = 16;

    // Random bytes sent per limit setting.
    localparam int BYTES_PER_SETTING = 100;

    // Members are normally cut short at this size to keep the run brisk.
    localparam int NORMAL_CAP = 300;

    // Largest header byte count before the counter itself overflows.
    localparam longint unsigned COUNT_MAX = (64'd1 << LEN_BITS) - 1;

    localparam logic [7:0] CM_DEFLATE = 8'd8;

    // Tracks the parser state byte by byte and keeps the results that the block
    // still owes us, oldest first.
    class header_result_board;
        logic [CFG_W-1:0] hdr_limit;
        t_phase           phase;
        longint unsigned  byte_cnt;
        logic [7:0]       flg_seen;
        logic [7:0]       cm_seen;
        logic [15:0]      skip_left;
        logic [7:0]       xlen_lo;
        t_out_req         awaited_results[$];
        int unsigned      fail_cnt;

        function new();
            hdr_limit = MAX_LEN_RESET;
            fail_cnt = 0;
            rearm();
        endfunction

        function void rearm();
            phase = PH_MAGIC1;
            byte_cnt = 0;
            flg_seen = 8'h00;
            cm_seen = 8'h00;
            skip_left = 16'h0000;
            xlen_lo = 8'h00;
        endfunction

        // The optional parts follow one another in a fixed order; return the phase
        // of the first one present, starting the search at the given part.
        function t_phase part_after(t_part from);
            if (from == PART_EXTRA && (flg_seen & FLG_EXTRA) != 8'h00)
                return PH_XLEN_LO;
            if (from <= PART_NAME && (flg_seen & FLG_NAME) != 8'h00)
                return PH_NAME;
            if (from <= PART_COMMENT && (flg_seen & FLG_COMMENT) != 8'h00)
                return PH_COMMENT;
            if ((flg_seen & FLG_HCRC) != 8'h00) begin
                skip_left = HCRC_SKIP;
                return PH_HCRC;
            end
            return PH_COMPLETE;
        endfunction

        function void note_byte(t_in_req req);
            logic [7:0]      b;
            longint unsigned count;
            longint unsigned limit;
            bit              active;
            bit              has_res;
            t_status         st;
            t_out_req        res;
            b = req.data_byte;
            limit = (64'(hdr_limit) < COUNT_MAX) ? 64'(hdr_limit) : COUNT_MAX;
            active = (phase < PH_DRAIN);
            count = byte_cnt;
            has_res = 1'b0;
            st = ST_OK;
            if (active) begin
                count = byte_cnt + 1;
                case (phase)
                    PH_MAGIC1: begin
                        if (b != MAGIC_ID1) begin
                            has_res = 1'b1;
                            st = ST_NOT_GZIP;
                        end else begin
                            phase = PH_MAGIC2;
                        end
                    end
                    PH_MAGIC2: begin
                        if (b != MAGIC_ID2) begin
                            has_res = 1'b1;
                            st = ST_NOT_GZIP;
                        end else begin
                            phase = PH_METHOD;
                        end
                    end
                    PH_METHOD: begin
                        cm_seen = b;
                        phase = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        flg_seen = b;
                        skip_left = FIXED_SKIP;
                        phase = PH_FIXED;
                    end
                    PH_FIXED: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0) phase = part_after(PART_EXTRA);
                    end
                    PH_XLEN_LO: begin
                        xlen_lo = b;
                        phase = PH_XLEN_HI;
                    end
                    PH_XLEN_HI: begin
                        skip_left = {b, xlen_lo};
                        phase = (skip_left == 16'd0) ? part_after(PART_NAME) : PH_XDATA;
                    end
                    PH_XDATA: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0) phase = part_after(PART_NAME);
                    end
                    PH_NAME: begin
                        if (b == 8'h00) phase = part_after(PART_COMMENT);
                    end
                    PH_COMMENT: begin
                        if (b == 8'h00) phase = part_after(PART_HCRC);
                    end
                    default: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 16'd0) phase = PH_COMPLETE;
                    end
                endcase
                if (!has_res && phase == PH_COMPLETE) begin
                    has_res = 1'b1;
                    st = ST_OK;
                end
                // A bad magic byte wins over the length limit.
                if (!(has_res && st == ST_NOT_GZIP) && count > limit) begin
                    has_res = 1'b1;
                    st = ST_TOO_LONG;
                end
                if (!has_res && req.end_of_stream) begin
                    has_res = 1'b1;
                    st = ST_TRUNC;
                end
            end
            if (has_res) begin
                res.status = st;
                res.header_length = (st == ST_OK) ? 16'(count) : 16'h0000;
                res.flag_byte = flg_seen;
                res.method_byte = cm_seen;
                awaited_results.push_back(res);
            end
            if (req.end_of_stream) begin
                rearm();
            end else begin
                if (has_res || !active) phase = PH_DRAIN;
                byte_cnt = count;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_cnt++;
            end
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: status %0d, length %0d",
                       got.status, got.header_length);
                fail_cnt++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("header_length", want.header_length, got.header_length);
            compare_field("flag_byte", 16'(want.flag_byte), 16'(got.flag_byte));
            compare_field("method_byte", 16'(want.method_byte), 16'(got.method_byte));
        endfunction
    endclass

    // Every input of the block starts from a known value.
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_req          i_in_req = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_req         o_out_req;

    header_result_board board;

    // Percentages of cycles in which each side holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Bytes of the member currently being assembled, and how large it may grow.
    logic [7:0] member_bytes[$];
    int         file_cap = NORMAL_CAP;
    int         setting_bytes = 0;
    int unsigned quiet_cycles = 0;

    gzip_header_length_parser_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_req      (i_in_req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_req     (o_out_req)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Result side. Everything is sampled just after the rising edge, so the values
    // seen are those the block saw at that edge. Ready is redrawn every cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_out_req);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: only a hung block leaves both channels still for this long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles < QUIET_LIMIT) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one byte, possibly after a random pause, and hold it until it is taken.
    // Valid stays high between back-to-back requests.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in_req req;
        req.data_byte = b;
        req.end_of_stream = eos;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_byte(req);
        setting_bytes++;
    endtask

    // The last byte of the assembled member carries end of stream.
    task automatic send_member();
        for (int i = 0; i < member_bytes.size(); i++)
            send_byte(member_bytes[i], i == member_bytes.size() - 1);
        member_bytes.delete();
    endtask

    function automatic void add_byte(input logic [7:0] b);
        if (member_bytes.size() < file_cap) member_bytes.push_back(b);
    endfunction

    // Append a well-formed member header and return its length as far as it was built.
    function automatic int add_header(input logic [7:0] flg, input logic [7:0] cm,
                                      input int xlen, input int name_len,
                                      input int comment_len);
        add_byte(MAGIC_ID1);
        add_byte(MAGIC_ID2);
        add_byte(cm);
        add_byte(flg);
        repeat (FIXED_HDR_LEN - 4) add_byte(8'($urandom_range(255)));
        if ((flg & FLG_EXTRA) != 8'h00) begin
            add_byte(8'(xlen));
            add_byte(8'(xlen >> 8));
            for (int i = 0; i < xlen && member_bytes.size() < file_cap; i++)
                add_byte(8'($urandom_range(255)));
        end
        if ((flg & FLG_NAME) != 8'h00) begin
            repeat (name_len) add_byte(8'($urandom_range(1, 255)));
            add_byte(8'h00);
        end
        if ((flg & FLG_COMMENT) != 8'h00) begin
            repeat (comment_len) add_byte(8'($urandom_range(1, 255)));
            add_byte(8'h00);
        end
        if ((flg & FLG_HCRC) != 8'h00) begin
            add_byte(8'($urandom_range(255)));
            add_byte(8'($urandom_range(255)));
        end
        return member_bytes.size();
    endfunction

    // Mostly well-formed members with random content; some are cut short or have a
    // damaged magic number, and a few are plain noise.
    task automatic send_random_member();
        int         kind;
        int         hdr_end;
        int         cut;
        int         xlen;
        logic [7:0] flg;
        logic [7:0] cm;
        kind = $urandom_range(99);
        if (kind < 15) begin
            if ($urandom_range(2) == 0) add_byte(MAGIC_ID1);
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        end else begin
            flg = 8'($urandom_range(255));
            cm = ($urandom_range(9) < 7) ? CM_DEFLATE : 8'($urandom_range(255));
            xlen = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(12);
            hdr_end = add_header(flg, cm, xlen, $urandom_range(8), $urandom_range(8));
            repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
            if (kind < 25) begin
                member_bytes[$urandom_range(1)] ^= 8'($urandom_range(1, 255));
            end else if (kind < 45) begin
                cut = $urandom_range(1, hdr_end);
                while (member_bytes.size() > cut) void'(member_bytes.pop_back());
            end
        end
        send_member();
    endtask

    // The limit may only change while the parser is quiet: all owed results back,
    // then a few more cycles for any byte still inside.
    task automatic write_limit(input logic [CFG_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.hdr_limit = value;
    endtask

    initial begin
        logic [CFG_W-1:0] limit;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed members under the reset limit, with the sender lightly idle and
        // the receiver heavily stalled.
        send_idle_pct = 18;
        recv_idle_pct = 65;
        // Plain header followed by data bytes that must produce nothing.
        void'(add_header(8'h00, CM_DEFLATE, 0, 0, 0));
        add_byte(8'h00);
        add_byte(8'hff);
        send_member();
        // Bad first magic byte on the only byte of the stream.
        add_byte(8'h00);
        send_member();
        // Bad second magic byte, then a byte to drain.
        add_byte(MAGIC_ID1);
        add_byte(8'hff);
        add_byte(8'h00);
        send_member();
        // Stream ends inside the fixed header.
        add_byte(MAGIC_ID1);
        add_byte(MAGIC_ID2);
        add_byte(CM_DEFLATE);
        send_member();
        // Every flag bit set, reserved ones too, an empty extra field and an
        // empty name; end of stream falls on the last header byte.
        void'(add_header(8'hff, 8'hff, 0, 0, 1));
        send_member();
        // Stream ending on a good first magic byte.
        add_byte(MAGIC_ID1);
        send_member();
        // Extra field and name together, with one trailing byte.
        void'(add_header(FLG_EXTRA | FLG_NAME, 8'h00, 3, 2, 0));
        add_byte(8'h5a);
        send_member();

        // Random members across several limits. Idling moves from a stalled
        // receiver to a stalled sender, and finally to full speed on both sides.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: limit = CFG_W'(FIXED_HDR_LEN);
                1: limit = CFG_W'($urandom_range(11, 400));
                2: limit = '0;
                3: limit = CFG_W'($urandom_range(1, FIXED_HDR_LEN - 1));
                4: limit = '1;
                default: limit = MAX_LEN_RESET;
            endcase
            send_idle_pct = (p < 2) ? 18 : (p < 4) ? 65 : 0;
            recv_idle_pct = (p < 2) ? 65 : (p < 4) ? 18 : 0;
            write_limit(limit);
            if (p == 5) begin
                // At the reset limit: a header that is exactly as long as the
                // limit allows, and one that runs past it inside the extra field.
                void'(add_header(FLG_EXTRA, CM_DEFLATE,
                                 int'(MAX_LEN_RESET) - FIXED_HDR_LEN - 2, 0, 0));
                add_byte(8'h33);
                send_member();
                void'(add_header(8'hff, CM_DEFLATE, 65535, 1, 1));
                send_member();
            end
            setting_bytes = 0;
            while (setting_bytes < BYTES_PER_SETTING) send_random_member();
        end

        i_in_valid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
